### design/bgps_pkg.sv
package bgps_pkg;

	// Default counter widths
	localparam int unsigned MSG_COUNT_BITS_DEF   = 32;
	localparam int unsigned RETRY_COUNT_BITS_DEF = 16;

	// Hold time after reset, in seconds
	localparam logic [15:0] HOLD_TIME_RST = 16'd90;

	// Session phases
	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_CONNECT     = 3'd1;
	localparam logic [2:0] PH_ACTIVE      = 3'd2;
	localparam logic [2:0] PH_OPENSENT    = 3'd3;
	localparam logic [2:0] PH_OPENCONFIRM = 3'd4;
	localparam logic [2:0] PH_ESTABLISHED = 3'd5;

	// Session events
	localparam logic [3:0] EV_START     = 4'd0;
	localparam logic [3:0] EV_RETRY_EXP = 4'd1;
	localparam logic [3:0] EV_HOLD_EXP  = 4'd2;
	localparam logic [3:0] EV_KA_EXP    = 4'd3;
	localparam logic [3:0] EV_TCP_OK    = 4'd4;
	localparam logic [3:0] EV_TCP_FAIL  = 4'd5;
	localparam logic [3:0] EV_OPEN_MSG  = 4'd6;
	localparam logic [3:0] EV_KA_MSG    = 4'd7;
	localparam logic [3:0] EV_UPDATE    = 4'd8;

	// Retry timer commands
	localparam logic [1:0] RT_NONE    = 2'd0;
	localparam logic [1:0] RT_RESTART = 2'd1;
	localparam logic [1:0] RT_STOP    = 2'd2;

	// Messages to send
	localparam logic [1:0] MSG_NONE      = 2'd0;
	localparam logic [1:0] MSG_OPEN      = 2'd1;
	localparam logic [1:0] MSG_KEEPALIVE = 2'd2;

	// Commands of one result
	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] retry_cmd;
		logic       hold;
		logic       ka;
		logic [1:0] msg;
		logic       drop;
		logic       listen;
		logic       open_conn;
	} act_t;

	// Counter updates of one event
	typedef struct packed {
		logic retry_clr;
		logic retry_inc;
		logic open_inc;
		logic ka_inc;
		logic upd_inc;
	} cnt_ctl_t;

endpackage

### design/bgps_in_stage.sv
module bgps_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] mode,
	input  logic       retry_timer_running,
	input  logic       adv,
	output logic       valid_s1,
	output logic [3:0] ev_s1,
	output logic       running_s1
);

	logic load;

	// Hold the event while the next stage cannot take it
	assign in_stall = valid_s1 & ~adv;
	assign load     = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			ev_s1      <= mode;
			running_s1 <= retry_timer_running;
		end
	end

endmodule

### design/bgps_step.sv
module bgps_step (
	input  logic              [2:0] phase,
	input  logic              [3:0] ev,
	input  logic                    running,
	input  logic                    hold_nz,
	output bgps_pkg::act_t          act,
	output bgps_pkg::cnt_ctl_t      ctl
);

	logic down;
	logic down_stop;
	logic up;
	bgps_pkg::act_t base;

	always_comb begin
		base      = '0;
		base.phase = phase;
		ctl       = '0;
		down      = 1'b0;
		down_stop = 1'b1;
		up        = 1'b0;
		unique case (phase)
			bgps_pkg::PH_IDLE: begin
				if (ev == bgps_pkg::EV_START) begin
					ctl.retry_clr  = 1'b1;
					base.retry_cmd = bgps_pkg::RT_RESTART;
					base.listen    = 1'b1;
					base.open_conn = 1'b1;
					base.phase     = bgps_pkg::PH_CONNECT;
				end
			end
			bgps_pkg::PH_CONNECT: begin
				down_stop = running;
				unique case (ev)
					bgps_pkg::EV_RETRY_EXP: begin
						base.drop      = 1'b1;
						base.retry_cmd = bgps_pkg::RT_RESTART;
						base.open_conn = 1'b1;
					end
					bgps_pkg::EV_HOLD_EXP, bgps_pkg::EV_KA_EXP: begin
						down = 1'b1;
					end
					bgps_pkg::EV_TCP_OK: begin
						up = 1'b1;
					end
					bgps_pkg::EV_TCP_FAIL: begin
						base.phase = bgps_pkg::PH_ACTIVE;
					end
					bgps_pkg::EV_KA_MSG: begin
						ctl.ka_inc = 1'b1;
						down       = 1'b1;
					end
					bgps_pkg::EV_UPDATE: begin
						ctl.upd_inc = 1'b1;
						down        = 1'b1;
					end
					default: begin
					end
				endcase
			end
			bgps_pkg::PH_ACTIVE: begin
				unique case (ev)
					bgps_pkg::EV_RETRY_EXP: begin
						base.retry_cmd = bgps_pkg::RT_RESTART;
						base.open_conn = 1'b1;
						base.phase     = bgps_pkg::PH_CONNECT;
					end
					bgps_pkg::EV_HOLD_EXP, bgps_pkg::EV_KA_EXP: begin
						down = 1'b1;
					end
					bgps_pkg::EV_TCP_OK: begin
						up = 1'b1;
					end
					bgps_pkg::EV_TCP_FAIL: begin
						base.phase = bgps_pkg::PH_IDLE;
					end
					bgps_pkg::EV_OPEN_MSG: begin
						ctl.open_inc = 1'b1;
						down         = 1'b1;
					end
					bgps_pkg::EV_KA_MSG: begin
						ctl.ka_inc = 1'b1;
						down       = 1'b1;
					end
					bgps_pkg::EV_UPDATE: begin
						ctl.upd_inc = 1'b1;
						down        = 1'b1;
					end
					default: begin
					end
				endcase
			end
			bgps_pkg::PH_OPENSENT: begin
				unique case (ev)
					bgps_pkg::EV_RETRY_EXP, bgps_pkg::EV_HOLD_EXP,
					bgps_pkg::EV_KA_EXP: begin
						down = 1'b1;
					end
					bgps_pkg::EV_TCP_FAIL: begin
						base.drop      = 1'b1;
						base.retry_cmd = bgps_pkg::RT_RESTART;
						base.listen    = 1'b1;
						base.phase     = bgps_pkg::PH_ACTIVE;
					end
					bgps_pkg::EV_OPEN_MSG: begin
						ctl.open_inc   = 1'b1;
						base.retry_cmd = bgps_pkg::RT_STOP;
						base.msg       = bgps_pkg::MSG_KEEPALIVE;
						base.ka        = 1'b1;
						base.hold      = 1'b1;
						base.phase     = bgps_pkg::PH_OPENCONFIRM;
					end
					bgps_pkg::EV_KA_MSG: begin
						ctl.ka_inc = 1'b1;
						down       = 1'b1;
					end
					bgps_pkg::EV_UPDATE: begin
						ctl.upd_inc = 1'b1;
						down        = 1'b1;
					end
					default: begin
					end
				endcase
			end
			bgps_pkg::PH_OPENCONFIRM: begin
				unique case (ev)
					bgps_pkg::EV_RETRY_EXP, bgps_pkg::EV_HOLD_EXP: begin
						down = 1'b1;
					end
					bgps_pkg::EV_KA_EXP: begin
						base.msg = bgps_pkg::MSG_KEEPALIVE;
						base.ka  = 1'b1;
					end
					bgps_pkg::EV_TCP_FAIL: begin
						base.phase = bgps_pkg::PH_IDLE;
					end
					bgps_pkg::EV_OPEN_MSG: begin
						ctl.open_inc = 1'b1;
						down         = 1'b1;
					end
					bgps_pkg::EV_KA_MSG: begin
						ctl.ka_inc = 1'b1;
						base.hold  = 1'b1;
						base.phase = bgps_pkg::PH_ESTABLISHED;
					end
					bgps_pkg::EV_UPDATE: begin
						ctl.upd_inc = 1'b1;
						down        = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
				// established
				unique case (ev)
					bgps_pkg::EV_RETRY_EXP, bgps_pkg::EV_HOLD_EXP: begin
						down = 1'b1;
					end
					bgps_pkg::EV_KA_EXP: begin
						base.msg = bgps_pkg::MSG_KEEPALIVE;
						base.ka  = hold_nz;
					end
					bgps_pkg::EV_OPEN_MSG: begin
						ctl.open_inc = 1'b1;
					end
					bgps_pkg::EV_KA_MSG: begin
						ctl.ka_inc = 1'b1;
						base.hold  = hold_nz;
					end
					bgps_pkg::EV_UPDATE: begin
						ctl.upd_inc = 1'b1;
						base.hold   = hold_nz;
					end
					default: begin
					end
				endcase
			end
		endcase
		// Every teardown counts a retry
		ctl.retry_inc = down;
	end

	// Fold in teardown and connection-up actions
	always_comb begin
		act = base;
		if (down) begin
			act.drop  = 1'b1;
			act.phase = bgps_pkg::PH_IDLE;
			if (down_stop) begin
				act.retry_cmd = bgps_pkg::RT_STOP;
			end
		end
		if (up) begin
			act.retry_cmd = bgps_pkg::RT_STOP;
			act.msg       = bgps_pkg::MSG_OPEN;
			act.hold      = 1'b1;
			act.phase     = bgps_pkg::PH_OPENSENT;
		end
	end

endmodule

### design/bgps_out_stage.sv
module bgps_out_stage #(
	parameter int unsigned MSG_COUNT_BITS   = bgps_pkg::MSG_COUNT_BITS_DEF,
	parameter int unsigned RETRY_COUNT_BITS = bgps_pkg::RETRY_COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  bgps_pkg::act_t              act,
	input  logic [RETRY_COUNT_BITS-1:0] retry_nx,
	input  logic [MSG_COUNT_BITS-1:0]   open_nx,
	input  logic [MSG_COUNT_BITS-1:0]   ka_nx,
	input  logic [MSG_COUNT_BITS-1:0]   upd_nx,
	input  logic                        out_stall,
	output logic                        adv,
	output logic                        out_valid,
	output bgps_pkg::act_t              act_s2,
	output logic [RETRY_COUNT_BITS-1:0] retry_s2,
	output logic [MSG_COUNT_BITS-1:0]   open_s2,
	output logic [MSG_COUNT_BITS-1:0]   ka_s2,
	output logic [MSG_COUNT_BITS-1:0]   upd_s2
);

	// Advance when the result register is empty or being drained
	assign adv = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			act_s2   <= act;
			retry_s2 <= retry_nx;
			open_s2  <= open_nx;
			ka_s2    <= ka_nx;
			upd_s2   <= upd_nx;
		end
	end

endmodule

### design/bgp_session_fsm.sv
// Pipeline: two register stages (event register, then result register) lie between an accepted
// transaction and its result at out_valid.
// Throughput: one event per clock cycle unless out_stall holds a result; the session state
// updates in the same cycle as the result register loads, so the next event sees it at once.
// Reset: arst_n clears phase to Idle, all counters to zero, hold_time to 90, both stages empty.
module bgp_session_fsm #(
	parameter int unsigned MSG_COUNT_BITS   = bgps_pkg::MSG_COUNT_BITS_DEF,
	parameter int unsigned RETRY_COUNT_BITS = bgps_pkg::RETRY_COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [15:0]                 hold_time,
	// event channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  mode,
	input  logic                        retry_timer_running,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  session_state,
	output logic [1:0]                  retry_timer_cmd,
	output logic                        restart_hold_timer,
	output logic                        restart_keepalive_timer,
	output logic [1:0]                  send_message,
	output logic                        drop_connection,
	output logic                        listen_for_peer,
	output logic                        open_connection,
	output logic [RETRY_COUNT_BITS-1:0] retry_count,
	output logic [MSG_COUNT_BITS-1:0]   opens_received,
	output logic [MSG_COUNT_BITS-1:0]   keepalives_received,
	output logic [MSG_COUNT_BITS-1:0]   updates_received
);

	// Session state
	logic [2:0]                  phase_q;
	logic [RETRY_COUNT_BITS-1:0] retry_q;
	logic [MSG_COUNT_BITS-1:0]   open_cnt_q;
	logic [MSG_COUNT_BITS-1:0]   ka_cnt_q;
	logic [MSG_COUNT_BITS-1:0]   upd_cnt_q;
	logic [15:0]                 hold_time_q;

	// Pipeline
	logic                        valid_s1;
	logic [3:0]                  ev_s1;
	logic                        running_s1;
	logic                        adv;
	logic                        fire;
	bgps_pkg::act_t              act;
	bgps_pkg::cnt_ctl_t          ctl;
	bgps_pkg::act_t              act_s2;

	// Counter values after the event
	logic [RETRY_COUNT_BITS-1:0] retry_nx;
	logic [MSG_COUNT_BITS-1:0]   open_nx;
	logic [MSG_COUNT_BITS-1:0]   ka_nx;
	logic [MSG_COUNT_BITS-1:0]   upd_nx;

	// Configuration: the user must let writes arrive only while idle; the block takes all
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= bgps_pkg::HOLD_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			hold_time_q <= hold_time;
		end
	end

	// Event register: hold the event until the result register can take its result
	bgps_in_stage u_in (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.mode                (mode),
		.retry_timer_running (retry_timer_running),
		.adv                 (adv),
		.valid_s1            (valid_s1),
		.ev_s1               (ev_s1),
		.running_s1          (running_s1)
	);

	// Decode the event against the current phase
	bgps_step u_step (
		.phase   (phase_q),
		.ev      (ev_s1),
		.running (running_s1),
		.hold_nz (|hold_time_q),
		.act     (act),
		.ctl     (ctl)
	);

	// Retry counter: clear on manual start, otherwise saturate at all ones
	always_comb begin
		retry_nx = retry_q;
		if (ctl.retry_clr) begin
			retry_nx = '0;
		end else if (ctl.retry_inc && (retry_q != {RETRY_COUNT_BITS{1'b1}})) begin
			retry_nx = retry_q + RETRY_COUNT_BITS'(1);
		end
	end

	// Message counters wrap at their width
	assign open_nx = ctl.open_inc ? open_cnt_q + MSG_COUNT_BITS'(1) : open_cnt_q;
	assign ka_nx   = ctl.ka_inc   ? ka_cnt_q   + MSG_COUNT_BITS'(1) : ka_cnt_q;
	assign upd_nx  = ctl.upd_inc  ? upd_cnt_q  + MSG_COUNT_BITS'(1) : upd_cnt_q;

	// An event completes when it leaves the event register into the result register
	assign fire = valid_s1 & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bgps_pkg::PH_IDLE;
			retry_q    <= '0;
			open_cnt_q <= '0;
			ka_cnt_q   <= '0;
			upd_cnt_q  <= '0;
		end else if (fire) begin
			phase_q    <= act.phase;
			retry_q    <= retry_nx;
			open_cnt_q <= open_nx;
			ka_cnt_q   <= ka_nx;
			upd_cnt_q  <= upd_nx;
		end
	end

	// Result register: parts the decode from a stalled consumer
	bgps_out_stage #(
		.MSG_COUNT_BITS   (MSG_COUNT_BITS),
		.RETRY_COUNT_BITS (RETRY_COUNT_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.act       (act),
		.retry_nx  (retry_nx),
		.open_nx   (open_nx),
		.ka_nx     (ka_nx),
		.upd_nx    (upd_nx),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.act_s2    (act_s2),
		.retry_s2  (retry_count),
		.open_s2   (opens_received),
		.ka_s2     (keepalives_received),
		.upd_s2    (updates_received)
	);

	assign session_state           = act_s2.phase;
	assign retry_timer_cmd         = act_s2.retry_cmd;
	assign restart_hold_timer      = act_s2.hold;
	assign restart_keepalive_timer = act_s2.ka;
	assign send_message            = act_s2.msg;
	assign drop_connection         = act_s2.drop;
	assign listen_for_peer         = act_s2.listen;
	assign open_connection         = act_s2.open_conn;

	// A teardown always lands in Idle
	a_teardown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl.retry_inc |=> phase_q == bgps_pkg::PH_IDLE)
		else $error("teardown did not return to Idle");

	// Manual start clears the retry counter
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl.retry_clr |=> retry_q == '0)
		else $error("retry counter not cleared on start");

	// A saturated retry counter stays saturated until a start
	a_retry_sat: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !ctl.retry_clr && (retry_q == {RETRY_COUNT_BITS{1'b1}})
		|=> retry_q == {RETRY_COUNT_BITS{1'b1}})
		else $error("retry counter left saturation");

	// Sending OPEN goes with entry to OpenSent in the delivered result
	a_open_sent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act.msg == bgps_pkg::MSG_OPEN
		|=> out_valid && session_state == bgps_pkg::PH_OPENSENT)
		else $error("OPEN sent without entering OpenSent");

endmodule
